>>> hw/rtl/dns_name_label_encoder_core_assert.svh
// Assertion macros used by the label encoder core.
`ifndef DNS_NAME_LABEL_ENCODER_CORE_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define DNLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, disabled while in reset.
`define DNLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define DNLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DNLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/dnle_pkg.sv
// Shared types and constants of the DNS label encoder.
package dnle_pkg;

	localparam logic [7:0] DOT_CHAR  = 8'h2E;
	localparam logic [7:0] TERM_BYTE = 8'h00;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic store;      // write one label character
		logic load_len;   // present the length byte, reset read index
		logic rd_en;      // read the label store at the read index
		logic load_data;  // present the read character
		logic rd_next;    // advance the read index
		logic clr_label;  // drop the buffered label
		logic load_term;  // present the terminator, clear the error flag
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic len_zero;   // nothing buffered
		logic rd_last;    // read index is at the last character
		logic out_free;   // output register can take a word
	} status_t;

endpackage

>>> hw/rtl/dnle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dnle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 62
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/dnle_ctrl.sv
// Controller state machine of the DNS label encoder.
module dnle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              end_of_name,
	input  dnle_pkg::status_t status,
	output dnle_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_READ,
		S_DATA,
		S_TERM
	} state_t;

	state_t state_q, state_d;
	logic   eon_q, eon_d;
	logic   accept;
	logic   is_dot;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign is_dot   = (ch == dnle_pkg::DOT_CHAR);

	// Decode next state and datapath commands
	always_comb begin
		state_d = state_q;
		eon_d   = eon_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (end_of_name || is_dot) begin
						eon_d = end_of_name;
						if (!status.len_zero) begin
							state_d = S_LEN;
						end else if (end_of_name) begin
							state_d = S_TERM;
						end
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			S_LEN: begin
				if (status.out_free) begin
					cmd.load_len = 1'b1;
					state_d      = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_DATA;
			end
			S_DATA: begin
				if (status.out_free) begin
					cmd.load_data = 1'b1;
					if (status.rd_last) begin
						cmd.clr_label = 1'b1;
						state_d       = eon_q ? S_TERM : S_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			S_TERM: begin
				if (status.out_free) begin
					cmd.load_term = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the end-of-name flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eon_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			eon_q   <= eon_d;
		end
	end

endmodule

>>> hw/rtl/dnle_dp.sv
// Datapath of the DNS label encoder: label store, counters, output register.
module dnle_dp #(
	parameter int MAX_LABEL = 62
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        ch,
	input  dnle_pkg::cmd_t    cmd,
	output dnle_pkg::status_t status,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last,
	output logic              label_overflow
);

	localparam int LW = $clog2(MAX_LABEL + 1);
	localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

	logic [LW-1:0] len_q;
	logic [AW-1:0] idx_q;
	logic          ovf_q;
	logic          not_full;
	logic          wr_en;
	logic [7:0]    rdata;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;
	logic          out_ovf_q;

	assign not_full = (len_q < LW'(MAX_LABEL));
	assign wr_en    = cmd.store && not_full;

	assign status.len_zero = (len_q == '0);
	assign status.rd_last  = ((LW'(idx_q) + LW'(1)) == len_q);
	assign status.out_free = !out_valid_q || !out_stall;

	dnle_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LABEL)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[AW-1:0]),
		.wdata(ch),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rdata)
	);

	// Count buffered characters, set the sticky truncation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.clr_label) begin
				len_q <= '0;
			end else if (wr_en) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.load_term) begin
				ovf_q <= 1'b0;
			end else if (cmd.store && !not_full) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Advance the read index through the label
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_len) begin
			idx_q <= '0;
		end else if (cmd.rd_next) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_len || cmd.load_data || cmd.load_term) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			out_byte_q <= 8'(len_q);
			last_q     <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else if (cmd.load_data) begin
			out_byte_q <= rdata;
			last_q     <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else if (cmd.load_term) begin
			out_byte_q <= dnle_pkg::TERM_BYTE;
			last_q     <= 1'b1;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign last           = last_q;
	assign label_overflow = out_ovf_q;

endmodule

>>> hw/rtl/dns_name_label_encoder_core.sv
// DNS name label encoder: dotted name in, one character per word; wire form out.
// Characters are taken at one per cycle while in_stall is low; out_stall holds the output.
// A dot or end of name with n > 0 buffered characters loads the length byte, then for each
// byte reads the label store (registered read) and loads the read character; end of name
// adds the terminator; a bare dot emits nothing, a bare end of name only the terminator.
// Words show in the cycle after their load; reset (arst_n low) clears all but store and payload.
`include "dns_name_label_encoder_core_assert.svh"

module dns_name_label_encoder_core #(
	parameter int MAX_LABEL = 62
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       end_of_name,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       label_overflow
);

	dnle_pkg::cmd_t    cmd;
	dnle_pkg::status_t status;

	dnle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ch         (ch),
		.end_of_name(end_of_name),
		.status     (status),
		.cmd        (cmd)
	);

	dnle_dp #(
		.MAX_LABEL(MAX_LABEL)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ch            (ch),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last          (last),
		.label_overflow(label_overflow)
	);

	// Terminator word is always a zero byte
	`DNLE_ASSERT_IMPLIES(a_term_zero, clk, arst_n, out_valid && last, out_byte == 8'h00)
	// Error flag only rides on the terminator
	`DNLE_ASSERT_IMPLIES(a_ovf_on_term, clk, arst_n, out_valid && label_overflow, last)
	// No word is taken while the label is being drained
	`DNLE_ASSERT_IMPLIES(a_no_accept_drain, clk, arst_n, in_valid && !in_stall,
		!cmd.rd_en && !cmd.load_data && !cmd.load_term)
	// A read is always followed by a wait for the data load
	`DNLE_ASSERT_NEXT(a_read_then_data, clk, arst_n, cmd.rd_en, !cmd.rd_en && in_stall)

endmodule
